// ----- rtl/bitmap_integer_set_top_assert.svh -----
// Assertion macros shared by the checker of the bitmap set block.
`ifndef BITMAP_INTEGER_SET_TOP_ASSERT_SVH
`define BITMAP_INTEGER_SET_TOP_ASSERT_SVH

// Clocked property check, disabled while reset is high.
`define BIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define BIS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/bis_pkg.sv -----
// Shared constants for the bitmap integer set block.
`default_nettype none
package bis_pkg;

  // Operation codes carried in the request kind field.
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_TEST   = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_NEXT   = 3'd4;

  // Field widths.
  localparam int OP_W    = 3;
  localparam int ELEM_W  = 16;
  localparam int FOUND_W = 11;
  localparam int COUNT_W = 12;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = 5;

  // Stream widths.
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 32;

  // Result field positions in the output data word.
  localparam int HIT_POS   = 0;
  localparam int FOUND_LSB = 1;
  localparam int COUNT_LSB = FOUND_LSB + FOUND_W;
  localparam int OOR_POS   = COUNT_LSB + COUNT_W;
  localparam int OUT_PAD_W = OUT_DATA_W - OOR_POS - 1;

endpackage
`default_nettype wire

// ----- rtl/bis_ffs.sv -----
// Find-first-set over one bitmap word.
`default_nettype none
module bis_ffs (
  input  logic [bis_pkg::WORD_W-1:0] bits,
  output logic                       any,
  output logic [bis_pkg::BIT_W-1:0]  idx
);
  import bis_pkg::*;

  // Lowest set bit wins; scan from the top so the last match is the lowest.
  always_comb begin
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = BIT_W'(i);
      end
    end
    any = |bits;
  end

endmodule
`default_nettype wire

// ----- rtl/bitmap_integer_set_top.sv -----
// Bitmap integer set: word memory, request sequencer and result register.
//
// Requests arrive on the s_ channel (element in s_tdata, operation and the
// start-fresh flag in s_tuser); one result per request leaves on the m_
// channel. The set lives in a WORD_COUNT x 32 bit memory with a registered
// read port, beside a running member count.
// Add, remove, test and unknown operations read the word when accepted; it
// is modified, written back and reported in the read-modify-write state,
// which waits while the output register is still full.
// Find-next reads one word per cycle from the start word until a set bit or
// the last word; a start at or beyond capacity takes the read-modify-write
// path. Clear writes zeros to every word, one word per cycle, then answers.
// Only one request is in work at a time; s_tready is high only while the
// block is idle, and the next request may be accepted while a result still
// waits in the output register.
// After reset the block runs a clearing pass over every word with s_tready
// low. When m_tready stays low, the finished result holds in the output
// register and the next request waits before its write-back.
`default_nettype none
module bitmap_integer_set_top #(
  parameter int WORD_COUNT = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bis_pkg::IN_DATA_W-1:0]    s_tdata,  // [15:0] element
  input  logic [bis_pkg::IN_USER_W-1:0]    s_tuser,  // [2:0] operation, [3] start_fresh
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bis_pkg::OUT_DATA_W-1:0]   m_tdata   // [0] hit, [11:1] found_element,
                                                     // [23:12] member_count, [24] out_of_range
);
  import bis_pkg::*;

  localparam int WI  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int EW  = WI + BIT_W;
  localparam int CAP = WORD_COUNT * WORD_W;
  localparam int CW  = $clog2(CAP + 1);
  localparam logic [WI-1:0] LAST = WI'(WORD_COUNT - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RMW   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;

  logic [2:0]        state;
  logic [OP_W-1:0]   op_q;
  logic [BIT_W-1:0]  bit_q;
  logic [WI-1:0]     word_q;
  logic              inside_q;
  logic              first;
  logic [WI-1:0]     data_word;
  logic [WI-1:0]     scan_addr;
  logic [WI-1:0]     clr_addr;
  logic              clr_resp;
  logic [CW-1:0]     count;
  logic              res_hit;
  logic [EW-1:0]     res_found;

  logic              out_hit;
  logic [FOUND_W-1:0] out_found;
  logic [COUNT_W-1:0] out_count;
  logic              out_oor;

  // Request fields.
  logic [OP_W-1:0] op_in;
  logic            fresh_in;
  logic [31:0]     elem32;
  logic [31:0]     start32;
  logic            in_inside;
  logic            start_inside;
  logic [WI-1:0]   in_word;
  logic [BIT_W-1:0] in_bit;
  logic            accept;
  logic            out_free;
  logic            res_load;

  assign op_in        = s_tuser[OP_W-1:0];
  assign fresh_in     = s_tuser[OP_W];
  assign elem32       = 32'(s_tdata[ELEM_W-1:0]);
  assign start32      = fresh_in ? 32'd0 : elem32 + 32'd1;
  assign in_inside    = elem32 < 32'(CAP);
  assign start_inside = start32 < 32'(CAP);
  assign in_word      = (op_in == OP_NEXT) ? start32[EW-1:BIT_W] : elem32[EW-1:BIT_W];
  assign in_bit       = (op_in == OP_NEXT) ? start32[BIT_W-1:0] : elem32[BIT_W-1:0];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign res_load = ((state == S_RMW) || (state == S_DONE)) && out_free;

  // Word memory with a registered read port.
  logic [WORD_W-1:0] mem [WORD_COUNT];
  logic [WORD_W-1:0] rd_data;
  logic [WI-1:0]     rd_addr;
  logic              wr_en;
  logic [WI-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read address follows the request, the scan pointer or the held word.
  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = in_word;
      S_SCAN:  rd_addr = scan_addr;
      default: rd_addr = word_q;
    endcase
  end

  // Read-modify-write of one word for add, remove and test.
  logic              bit_set;
  logic [WORD_W-1:0] bit_mask;
  logic              rmw_write;
  logic [WORD_W-1:0] rmw_word;
  logic [CW-1:0]     rmw_count;
  logic              rmw_hit;
  logic              rmw_oor;

  assign bit_set  = rd_data[bit_q];
  assign bit_mask = WORD_W'(1) << bit_q;

  always_comb begin
    rmw_write = 1'b0;
    rmw_word  = rd_data;
    rmw_count = count;
    rmw_hit   = 1'b0;
    rmw_oor   = 1'b0;
    case (op_q)
      OP_ADD: begin
        if (!inside_q) begin
          rmw_oor = 1'b1;
        end else begin
          rmw_hit = 1'b1;
          if (!bit_set) begin
            rmw_write = 1'b1;
            rmw_word  = rd_data | bit_mask;
            rmw_count = count + CW'(1);
          end
        end
      end
      OP_REMOVE: begin
        if (!inside_q) begin
          rmw_oor = 1'b1;
        end else if (bit_set) begin
          rmw_hit   = 1'b1;
          rmw_write = 1'b1;
          rmw_word  = rd_data & ~bit_mask;
          rmw_count = count - CW'(1);
        end
      end
      OP_TEST: begin
        if (!inside_q) begin
          rmw_oor = 1'b1;
        end else begin
          rmw_hit = bit_set;
        end
      end
      default: begin
      end
    endcase
  end

  // Memory write port: clearing sweep or write-back.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = word_q;
    wr_data = rmw_word;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (state == S_RMW && out_free) begin
      wr_en = rmw_write;
    end
  end

  // Scan: mask off bits below the start in the first word, then find the lowest.
  logic [WORD_W-1:0] scan_bits;
  logic              scan_any;
  logic [BIT_W-1:0]  scan_idx;

  assign scan_bits = first ? (rd_data & ({WORD_W{1'b1}} << bit_q)) : rd_data;

  bis_ffs u_ffs (
    .bits (scan_bits),
    .any  (scan_any),
    .idx  (scan_idx)
  );

  // Result fields masked to the output widths.
  logic [31:0] rmw_count32;
  logic [31:0] count32;
  logic [31:0] found32;

  assign rmw_count32 = 32'(rmw_count);
  assign count32     = 32'(count);
  assign found32     = 32'(res_found);

  // Sequencer, member count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      clr_resp <= 1'b0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // The result register fills when a request finishes and empties when taken.
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q      <= op_in;
            bit_q     <= in_bit;
            word_q    <= in_word;
            inside_q  <= in_inside;
            first     <= 1'b1;
            data_word <= in_word;
            scan_addr <= (in_word == LAST) ? in_word : in_word + WI'(1);
            clr_addr  <= '0;
            clr_resp  <= 1'b1;
            if (op_in == OP_CLEAR) begin
              state <= S_CLEAR;
            end else if (op_in == OP_NEXT && start_inside) begin
              state <= S_SCAN;
            end else begin
              state <= S_RMW;
            end
          end
        end
        S_RMW: begin
          if (out_free) begin
            out_hit   <= rmw_hit;
            out_found <= '0;
            out_count <= rmw_count32[COUNT_W-1:0];
            out_oor   <= rmw_oor;
            count     <= rmw_count;
            state     <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_any) begin
            res_hit   <= 1'b1;
            res_found <= {data_word, scan_idx};
            state     <= S_DONE;
          end else if (data_word == LAST) begin
            res_hit   <= 1'b0;
            res_found <= '0;
            state     <= S_DONE;
          end
          data_word <= scan_addr;
          scan_addr <= (scan_addr == LAST) ? scan_addr : scan_addr + WI'(1);
          first     <= 1'b0;
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + WI'(1);
          if (clr_addr == LAST) begin
            count     <= '0;
            res_hit   <= 1'b0;
            res_found <= '0;
            state     <= clr_resp ? S_DONE : S_IDLE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_hit   <= res_hit;
            out_found <= found32[FOUND_W-1:0];
            out_count <= count32[COUNT_W-1:0];
            out_oor   <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_oor, out_count, out_found, out_hit};

endmodule
`default_nettype wire

// ----- rtl/bis_chk.sv -----
// Port-level checker for the bitmap integer set block, with its bind.
`default_nettype none
`include "bitmap_integer_set_top_assert.svh"
module bis_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [bis_pkg::OUT_DATA_W-1:0] m_tdata,  // [0] hit, [11:1] found_element,
                                                  // [23:12] member_count, [24] out_of_range
  input logic                           m_tvalid,
  input logic                           m_tready
);
  import bis_pkg::*;

  logic             hit;
  logic             oor;
  logic [FOUND_W-1:0] found;

  assign hit   = m_tdata[HIT_POS];
  assign oor   = m_tdata[OOR_POS];
  assign found = m_tdata[COUNT_LSB-1:FOUND_LSB];

  // A stalled result holds its value.
  `BIS_ASSERT(a_result_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

  // One request at a time: ready drops right after an accept.
  `BIS_ASSERT(a_one_in_work, s_tvalid && s_tready |=> !s_tready, "second request accepted back to back")

  // The clearing pass follows reset, so no request is taken right after it.
  `BIS_ASSERT(a_clear_after_reset, $past(rst) |-> !s_tready, "request taken during clearing pass")

  // A found element is only reported with a hit.
  `BIS_ASSERT(a_found_needs_hit, m_tvalid && found != '0 |-> hit, "found element without hit")

  // Hit and out of range exclude each other.
  `BIS_NEVER(a_hit_oor, m_tvalid && hit && oor, "hit and out of range both set")

endmodule

bind bitmap_integer_set_top bis_chk u_bis_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
`default_nettype wire
